>>> rtl/stsc_pkg.sv
package stsc_pkg;

  // sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_FILT_ADD,
    ST_GAIN,
    ST_SQ_LOAD,
    ST_SQRT,
    ST_INTEG,
    ST_SUM,
    ST_CLAMP,
    ST_DONE
  } stsc_state_t;

  // register indexes
  localparam logic [2:0] CFG_OUT_MIN       = 3'd0;
  localparam logic [2:0] CFG_OUT_MAX       = 3'd1;
  localparam logic [2:0] CFG_OUT_OFFSET    = 3'd2;
  localparam logic [2:0] CFG_IDLE_LEVEL    = 3'd3;
  localparam logic [2:0] CFG_SPOOLUP_LEVEL = 3'd4;
  localparam logic [2:0] CFG_MIN_REF       = 3'd5;
  localparam logic [2:0] CFG_SQRT_GAIN     = 3'd6;
  localparam logic [2:0] CFG_INTEG_STEP    = 3'd7;

  // mode codes
  localparam logic [1:0] MODE_CONTROL  = 2'd0;
  localparam logic [1:0] MODE_DEADBAND = 2'd1;
  localparam logic [1:0] MODE_BYPASS   = 2'd2;
  localparam logic [1:0] MODE_SPOOLUP  = 2'd3;

  // clamp codes
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  // 0.9 in q16.16 and the 0.98 decay factor
  localparam logic signed [31:0] REF_POINT_NINE = 32'sd58983;
  localparam logic signed [32:0] DECAY_Q16      = 33'sd64225;

  // register reset values
  localparam logic signed [31:0] OUT_MIN_RST   = -32'sd65536000;
  localparam logic signed [31:0] OUT_MAX_RST   = 32'sd65536000;
  localparam logic [30:0]        SQRT_GAIN_RST = 31'd65536;

endpackage

>>> rtl/super_twisting_speed_controller.sv
// super-twisting sliding-mode speed controller, q16.16 fixed point. one sample word
// (reference, measured, fresh) yields one result word (drive, mode, clamp). a control
// sample runs a few steps on one shared 33x33 multiplier (error filter, gain product,
// integral decay), then a restoring square root that settles one result bit per cycle
// over 32 bits, then the integral update, sum and clamp. bypass, spoolup and deadband
// samples go from the decode at acceptance straight to the result register. the next
// sample is taken once the result is loaded, so a sample holds the input through all
// its steps and while its last step waits for a stalled previous result word.
// in_stall is high while a sample is in work; a finished word waits in the output
// register, so the next sample can be taken while the result is still stalled.
// configuration is written through cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
module super_twisting_speed_controller
  import stsc_pkg::*;
#(
  parameter int STALE_LIMIT = 50,
  parameter int TOL_LEVEL   = 0,
  parameter int FILTER_GAIN = 65536
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] measured,
  input  logic               fresh,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drive,
  output logic [1:0]         mode,
  output logic [1:0]         clamp,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [7:0]        STALE_MAX = 8'(STALE_LIMIT);
  localparam logic signed [32:0] TOL_S    = 33'(TOL_LEVEL);
  localparam logic signed [32:0] FGAIN_S  = 33'(FILTER_GAIN);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [31:0] out_min, out_max, out_offset, min_ref;
  logic [30:0]        idle_level, spoolup_level, sqrt_gain, integ_step;

  // loop state
  logic signed [31:0] out_reg, prev_error, integral;
  logic signed [1:0]  prev_sign;
  logic [7:0]         stale_count;

  // per-sample work registers
  stsc_state_t        state, state_next;
  logic signed [31:0] err;
  logic signed [1:0]  sgn;
  logic [31:0]        mag;
  logic [1:0]         item_mode, item_clamp;
  logic signed [65:0] prod;
  logic [63:0]        rad;
  logic [35:0]        rem;
  logic [31:0]        root;
  logic [4:0]         sq_count;

  logic in_take, out_take;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // sample decode at acceptance
  // ---------------------------------------------------------------------------
  logic signed [31:0] err_raw;
  logic               in_deadband;
  logic [7:0]         stale_next;
  logic               go_spool;
  logic signed [31:0] neg_off;
  logic               hit_low, hit_high;

  always_comb begin
    err_raw     = sat32(36'(reference) - 36'(measured));
    in_deadband = (33'(err_raw) < TOL_S) && (33'(err_raw) > -TOL_S);
    if (fresh) begin
      stale_next = 8'd0;
    end else if (stale_count != 8'hff) begin
      stale_next = stale_count + 8'd1;
    end else begin
      stale_next = stale_count;
    end
    go_spool = (stale_next >= STALE_MAX);
    neg_off  = 32'sd0 - out_offset;
    // clamp tests on the current internal output, lower limit first
    hit_low  = (out_reg <= out_min);
    hit_high = (out_reg >= out_max);
  end

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  // ---------------------------------------------------------------------------
  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        integ_abs;

  always_comb begin
    integ_abs = integral[31] ? (~integral + 32'd1) : integral;
    case (state)
      ST_FILT: begin
        mul_a = 33'(err) - 33'(prev_error);
        mul_b = FGAIN_S;
      end
      ST_GAIN: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({2'b00, sqrt_gain});
      end
      ST_SQ_LOAD: begin
        mul_a = $signed({1'b0, integ_abs});
        mul_b = DECAY_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  logic signed [65:0] prod_sh;
  logic signed [35:0] filt_sum;
  logic signed [31:0] err_filt;
  logic [35:0]        rem_sh, trial;
  logic signed [2:0]  ksum;
  logic [31:0]        kstep;
  logic signed [35:0] integ_sum;
  logic [31:0]        decay_mag;
  logic signed [35:0] prop, out_sum;

  always_comb begin
    // floor of the filtered delta, then back onto the previous error
    prod_sh  = prod >>> 16;
    filt_sum = $signed(prod_sh[35:0]) + 36'(prev_error);
    err_filt = sat32(filt_sum);
    // one restoring square-root step
    rem_sh   = {rem[33:0], rad[63:62]};
    trial    = {2'b00, root, 2'b01};
    // trapezoidal sign step: (sgn + prev_sign) * integ_step
    ksum     = 3'(sgn) + 3'(prev_sign);
    case (ksum)
      3'sd2, -3'sd2: kstep = {integ_step, 1'b0};
      3'sd1, -3'sd1: kstep = {1'b0, integ_step};
      default:       kstep = 32'd0;
    endcase
    integ_sum = ksum[2] ? (36'(integral) - $signed({4'd0, kstep}))
                        : (36'(integral) + $signed({4'd0, kstep}));
    decay_mag = prod[47:16];
    prop      = sgn[1] ? -$signed({4'd0, root}) : $signed({4'd0, root});
    out_sum   = prop + 36'(integral);
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (reference < min_ref || go_spool || in_deadband) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FILT;
          end
        end
      end
      ST_FILT:     state_next = ST_FILT_ADD;
      ST_FILT_ADD: state_next = ST_GAIN;
      ST_GAIN:     state_next = ST_SQ_LOAD;
      ST_SQ_LOAD:  state_next = ST_SQRT;
      ST_SQRT: begin
        if (sq_count == 5'd31) begin
          state_next = ST_INTEG;
        end
      end
      ST_INTEG: state_next = ST_SUM;
      ST_SUM:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE: begin
        // the result register must be free or emptying this cycle
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_min       <= OUT_MIN_RST;
      out_max       <= OUT_MAX_RST;
      out_offset    <= '0;
      idle_level    <= '0;
      spoolup_level <= '0;
      min_ref       <= '0;
      sqrt_gain     <= SQRT_GAIN_RST;
      integ_step    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUT_MIN:       out_min       <= cfg_data;
        CFG_OUT_MAX:       out_max       <= cfg_data;
        CFG_OUT_OFFSET:    out_offset    <= cfg_data;
        CFG_IDLE_LEVEL:    idle_level    <= cfg_data[30:0];
        CFG_SPOOLUP_LEVEL: spoolup_level <= cfg_data[30:0];
        CFG_MIN_REF:       min_ref       <= cfg_data;
        CFG_SQRT_GAIN:     sqrt_gain     <= cfg_data[30:0];
        CFG_INTEG_STEP:    integ_step    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // multiplier product register, written only on the steps that use it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_FILT || state == ST_GAIN || state == ST_SQ_LOAD) begin
      prod <= 66'(mul_a) * 66'(mul_b);
    end
  end

  // ---------------------------------------------------------------------------
  // loop state and work registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg     <= '0;
      prev_error  <= '0;
      integral    <= '0;
      prev_sign   <= '0;
      stale_count <= '0;
      sq_count    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            err <= err_raw;
            if (reference < min_ref) begin
              // bypass: drive reads 0 or the idle level, loop cleared
              out_reg    <= (reference >= REF_POINT_NINE) ?
                            neg_off + $signed({1'b0, idle_level}) : neg_off;
              prev_error <= '0;
              prev_sign  <= '0;
              integral   <= '0;
              item_mode  <= MODE_BYPASS;
              item_clamp <= CLAMP_NONE;
            end else if (go_spool) begin
              stale_count <= STALE_MAX;
              out_reg     <= neg_off + $signed({1'b0, spoolup_level});
              prev_error  <= '0;
              prev_sign   <= '0;
              integral    <= '0;
              item_mode   <= MODE_SPOOLUP;
              item_clamp  <= CLAMP_NONE;
            end else begin
              stale_count <= stale_next;
              if (in_deadband) begin
                // hold: re-clamp the output only
                item_mode <= MODE_DEADBAND;
                if (hit_low) begin
                  out_reg    <= out_min;
                  item_clamp <= CLAMP_LOW;
                end else if (hit_high) begin
                  out_reg    <= out_max;
                  item_clamp <= CLAMP_HIGH;
                end else begin
                  item_clamp <= CLAMP_NONE;
                end
              end else begin
                item_mode  <= MODE_CONTROL;
                item_clamp <= CLAMP_NONE;
              end
            end
          end
        end
        ST_FILT_ADD: begin
          err <= err_filt;
          sgn <= (err_filt > 32'sd0) ? 2'sd1 : ((err_filt < 32'sd0) ? -2'sd1 : 2'sd0);
          mag <= err_filt[31] ? (~err_filt + 32'd1) : err_filt;
        end
        ST_SQ_LOAD: begin
          rad      <= prod[63:0];
          rem      <= '0;
          root     <= '0;
          sq_count <= '0;
        end
        ST_SQRT: begin
          rad      <= {rad[61:0], 2'b00};
          sq_count <= sq_count + 5'd1;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[30:0], 1'b0};
          end
        end
        ST_INTEG: begin
          // integrate while the old output is inside its limits, else decay
          if (!hit_low && !hit_high) begin
            integral <= sat32(integ_sum);
          end else if (integral[31]) begin
            integral <= 32'sd0 - $signed(decay_mag);
          end else begin
            integral <= $signed(decay_mag);
          end
        end
        ST_SUM: begin
          out_reg    <= sat32(out_sum);
          prev_error <= err;
          prev_sign  <= sgn;
        end
        ST_CLAMP: begin
          if (hit_low) begin
            out_reg    <= out_min;
            item_clamp <= CLAMP_LOW;
          end else if (hit_high) begin
            out_reg    <= out_max;
            item_clamp <= CLAMP_HIGH;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      drive <= out_reg + out_offset;
      mode  <= item_mode;
      clamp <= item_clamp;
    end
  end

endmodule
